[src/hors_pkg.sv]
`timescale 1ns / 1ps
// hors_pkg: shared types and codes for the heap-order record search unit.
// Used by hors_level_cell and heap_order_record_search_unit; no dependencies.

package hors_pkg;

  // Request kinds carried on the input tuser bit
  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_SEARCH = 1'b1;

  // Fixed field widths
  localparam int SLOT_W  = 7;
  localparam int HALF_W  = 64;
  localparam int CFG_W   = 8;
  localparam int IN_DW   = 264;  // 7 + 4*64 = 263, padded to whole bytes
  localparam int OUT_DW  = 128;
  localparam logic [CFG_W-1:0] CFG_RESET = 8'd128;

  // One stored record
  typedef struct packed {
    logic [HALF_W-1:0] name_high;
    logic [HALF_W-1:0] name_low;
    logic [HALF_W-1:0] meta_high;
    logic [HALF_W-1:0] meta_low;
  } rec_t;

  // Record write broadcast to every level
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    rec_t              rec;
  } wr_req_t;

  // Search token walking down the chain of levels
  typedef struct packed {
    logic              valid;
    logic              active;
    logic              found;
    logic [HALF_W-1:0] key_high;
    logic [HALF_W-1:0] key_low;
    logic [HALF_W-1:0] meta_high;
    logic [HALF_W-1:0] meta_low;
  } tok_t;

endpackage

[src/hors_level_cell.sv]
`timescale 1ns / 1ps
// hors_level_cell: one tree level; holds that level's records in a local memory
// and compares the passing search token. Depends on hors_pkg.

module hors_level_cell import hors_pkg::*; #(
  parameter int LEVEL       = 0,
  parameter int MAX_RECORDS = 128,
  parameter int NW          = 9,
  parameter int CW          = 9
) (
  input  logic          clk,
  input  logic          rst_n,
  input  wr_req_t       wr,
  input  logic [CW-1:0] limit,
  input  tok_t          tok_in,
  input  logic [NW-1:0] off_in,   // node offset within this level
  output tok_t          tok_out,
  output logic [NW-1:0] off_out   // child offset within the next level
);

  localparam int AW    = (LEVEL > 0) ? LEVEL : 1;
  localparam int DEPTH = 1 << AW;
  localparam int BASE  = (1 << LEVEL) - 1;
  localparam int NEXT  = 2 * BASE + 1;

  rec_t          mem [DEPTH];
  rec_t          rdata_r;
  tok_t          tok_r;
  logic [NW-1:0] off_r;

  logic [CW-1:0] slot_ext;
  logic          wr_hit;
  logic [CW-1:0] wr_off;
  logic [NW-1:0] node;
  logic          key_eq;
  logic          key_lt;

  // Write decode: does this slot belong to this level
  assign slot_ext = CW'(wr.slot);
  assign wr_hit   = wr.en && (slot_ext >= CW'(BASE)) && (slot_ext < CW'(NEXT)) &&
                    (slot_ext < CW'(MAX_RECORDS));
  assign wr_off   = slot_ext - CW'(BASE);

  // Level memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_hit) begin
      mem[wr_off[AW-1:0]] <= wr.rec;
    end
    rdata_r <= mem[off_in[AW-1:0]];
  end

  // Token register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r.valid <= tok_in.valid;
    end
    tok_r.active    <= tok_in.active;
    tok_r.found     <= tok_in.found;
    tok_r.key_high  <= tok_in.key_high;
    tok_r.key_low   <= tok_in.key_low;
    tok_r.meta_high <= tok_in.meta_high;
    tok_r.meta_low  <= tok_in.meta_low;
    off_r           <= off_in;
  end

  // Compare against the node read for this token
  assign node   = NW'(BASE) + off_r;
  assign key_eq = {tok_r.key_high, tok_r.key_low} == {rdata_r.name_high, rdata_r.name_low};
  assign key_lt = {tok_r.key_high, tok_r.key_low} <  {rdata_r.name_high, rdata_r.name_low};

  always_comb begin
    tok_out = tok_r;
    off_out = {off_r[NW-2:0], ~key_lt};
    if (tok_r.valid && tok_r.active) begin
      if (CW'(node) >= limit) begin
        tok_out.active = 1'b0;
      end else if (key_eq) begin
        tok_out.active    = 1'b0;
        tok_out.found     = 1'b1;
        tok_out.meta_high = rdata_r.meta_high;
        tok_out.meta_low  = rdata_r.meta_low;
      end
    end
  end

endmodule

[src/heap_order_record_search_unit.sv]
`timescale 1ns / 1ps
// heap_order_record_search_unit: top level; record page kept level by level in a
// chain of hors_level_cell instances. Depends on hors_pkg and hors_level_cell.
//
//  channel | ports                         | payload
//  --------+-------------------------------+-------------------------------------
//  in      | in_tvalid/in_tready           | tuser: action; tdata: slot_index,
//          |                               |   key_high, key_low, meta_in_high/low
//  out     | out_tvalid/out_tready         | tuser: found; tdata: meta_out_high/low
//  cfg     | cfg_valid/cfg_ready           | cfg_data: records_in_use
//
// One request at a time walks the chain, one tree level per cycle: the result passes
// through each level's token register in turn and then into the output register.
// The input reopens as the output register loads, so a new request is taken only
// once the last one has left the chain. Writes land in the level memory at acceptance.
// A result meeting a stalled output waits in a one-entry skid register and the input
// stays closed until it moves on. Sync active-low reset sets records_in_use to 128.

module heap_order_record_search_unit import hors_pkg::*; #(
  parameter int MAX_RECORDS = 128
) (
  input  logic              clk,
  input  logic              rst_n,
  // request stream
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,   // [6:0] slot_index, [70:7] key_high,
                                        // [134:71] key_low, [198:135] meta_in_high,
                                        // [262:199] meta_in_low, [263] zero
  input  logic              in_tuser,   // [0] action
  // result stream
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,  // [63:0] meta_out_high, [127:64] meta_out_low
  output logic              out_tuser,  // [0] found
  // configuration
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_W-1:0]  cfg_data
);

  localparam int LEVELS = $clog2(MAX_RECORDS + 1);
  localparam int NW     = LEVELS + 1;
  localparam int CW     = (NW > CFG_W) ? NW : CFG_W;

  logic [CFG_W-1:0] cfg_r;
  logic             busy_r, busy_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_found_r;
  logic [HALF_W-1:0] out_mh_r, out_ml_r;
  logic             pend_valid_r, pend_valid_nxt;
  logic             pend_found_r;
  logic [HALF_W-1:0] pend_mh_r, pend_ml_r;

  logic             in_acc;
  logic             out_free;
  logic             load_pend, load_chain, store_pend;
  logic [CW-1:0]    cfg_ext;
  logic [CW-1:0]    limit;
  wr_req_t          wr;

  tok_t             tok_w [LEVELS+1];
  logic [NW-1:0]    off_w [LEVELS+1];

  assign cfg_ready = 1'b1;
  assign in_tready = !busy_r;
  assign in_acc    = in_tvalid && in_tready;

  // Active record count, saturated at the store size
  assign cfg_ext = CW'(cfg_r);
  assign limit   = (cfg_ext > CW'(MAX_RECORDS)) ? CW'(MAX_RECORDS) : cfg_ext;

  // Record write request
  always_comb begin
    wr.en            = in_acc && (in_tuser == ACT_WRITE);
    wr.slot          = in_tdata[6:0];
    wr.rec.name_high = in_tdata[70:7];
    wr.rec.name_low  = in_tdata[134:71];
    wr.rec.meta_high = in_tdata[198:135];
    wr.rec.meta_low  = in_tdata[262:199];
  end

  // Token entering the root level; a write just rides through as a miss
  always_comb begin
    tok_w[0].valid     = in_acc;
    tok_w[0].active    = (in_tuser == ACT_SEARCH);
    tok_w[0].found     = 1'b0;
    tok_w[0].key_high  = in_tdata[70:7];
    tok_w[0].key_low   = in_tdata[134:71];
    tok_w[0].meta_high = '0;
    tok_w[0].meta_low  = '0;
    off_w[0]           = '0;
  end

  // Chain of level cells
  for (genvar g = 0; g < LEVELS; g++) begin : g_level
    hors_level_cell #(
      .LEVEL       (g),
      .MAX_RECORDS (MAX_RECORDS),
      .NW          (NW),
      .CW          (CW)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .wr      (wr),
      .limit   (limit),
      .tok_in  (tok_w[g]),
      .off_in  (off_w[g]),
      .tok_out (tok_w[g+1]),
      .off_out (off_w[g+1])
    );
  end

  // Output register and skid control
  assign out_free   = !out_valid_r || out_tready;
  assign load_pend  = pend_valid_r && out_free;
  assign load_chain = !pend_valid_r && tok_w[LEVELS].valid && out_free;
  assign store_pend = tok_w[LEVELS].valid && !load_chain;

  always_comb begin
    out_valid_nxt  = out_valid_r && !out_tready;
    pend_valid_nxt = pend_valid_r;
    busy_nxt       = busy_r;
    if (in_acc) begin
      busy_nxt = 1'b1;
    end
    if (load_pend) begin
      out_valid_nxt  = 1'b1;
      pend_valid_nxt = 1'b0;
      busy_nxt       = 1'b0;
    end else if (load_chain) begin
      out_valid_nxt = 1'b1;
      busy_nxt      = 1'b0;
    end else if (store_pend) begin
      pend_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r        <= CFG_RESET;
      busy_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cfg_r <= cfg_data;
      end
      busy_r       <= busy_nxt;
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (load_pend) begin
      out_found_r <= pend_found_r;
      out_mh_r    <= pend_mh_r;
      out_ml_r    <= pend_ml_r;
    end else if (load_chain) begin
      out_found_r <= tok_w[LEVELS].found;
      out_mh_r    <= tok_w[LEVELS].meta_high;
      out_ml_r    <= tok_w[LEVELS].meta_low;
    end
    if (store_pend) begin
      pend_found_r <= tok_w[LEVELS].found;
      pend_mh_r    <= tok_w[LEVELS].meta_high;
      pend_ml_r    <= tok_w[LEVELS].meta_low;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_found_r;
  assign out_tdata  = {out_ml_r, out_mh_r};

endmodule
